@@ design/priority_ready_queue_defines.svh @@
// assertion macros for the priority ready queue
// used by the top level; expects clk_i and rst_ni in scope
`ifndef PRIORITY_READY_QUEUE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_DEFINES_SVH

// plain property checked on every clock outside reset
`define PRQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication checked outside reset
`define PRQ_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define PRQ_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/prq_pkg.sv @@
// shared types and codes of the priority ready queue
// no dependencies
package prq_pkg;

  localparam int unsigned PID_W = 22;
  localparam int unsigned PRI_W = 8;
  localparam int unsigned CPU_W = 4;

  localparam logic [2:0] REQ_ENQ  = 3'd0;
  localparam logic [2:0] REQ_DEQ  = 3'd1;
  localparam logic [2:0] REQ_SORT = 3'd2;
  localparam logic [2:0] REQ_REM  = 3'd3;
  localparam logic [2:0] REQ_PEEK = 3'd4;
  localparam logic [2:0] REQ_SNAP = 3'd5;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [PRI_W-1:0] pri;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_SORT,
    CELL_MARK,
    CELL_SPREAD,
    CELL_SHIFT_MARKED
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     occupied;
    logic     tail;
    logic     sort_left;
    logic     sort_right;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT,
    S_REM_MARK,
    S_REM_SPREAD,
    S_REM_SHIFT,
    S_SNAP,
    S_ROT
  } st_e;

endpackage

@@ design/prq_cell.sv @@
// one queue slot: holds an entry and a remove mark, trades with its neighbors
// depends on prq_pkg
module prq_cell import prq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  entry_t           load_i,
  input  logic [PID_W-1:0] cmp_pid_i,
  input  entry_t           left_i,
  input  logic             left_mark_i,
  input  entry_t           right_i,
  output entry_t           ent_o,
  output logic             mark_o
);

  entry_t ent_q, ent_d;
  logic   mark_q, mark_d;

  always_comb begin
    ent_d  = ent_q;
    mark_d = mark_q;
    case (ctrl_i.op)
      CELL_LOAD: begin
        if (ctrl_i.tail) begin
          ent_d = load_i;
        end
      end
      CELL_SHIFT: begin
        ent_d = right_i;
      end
      CELL_SORT: begin
        if (ctrl_i.sort_left && (ent_q.pri > right_i.pri)) begin
          ent_d = right_i;
        end else if (ctrl_i.sort_right && (left_i.pri > ent_q.pri)) begin
          ent_d = left_i;
        end
      end
      CELL_MARK: begin
        mark_d = ctrl_i.occupied && (ent_q.pid == cmp_pid_i);
      end
      CELL_SPREAD: begin
        mark_d = mark_q | left_mark_i;
      end
      CELL_SHIFT_MARKED: begin
        if (mark_q) begin
          ent_d = right_i;
        end
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else begin
      mark_q <= mark_d;
    end
  end

  assign ent_o  = ent_q;
  assign mark_o = mark_q;

endmodule

@@ design/priority_ready_queue.sv @@
// priority ready queue top level: request fsm, occupancy and the cell chain
// depends on prq_pkg, prq_cell and priority_ready_queue_defines.svh
//
// - request channel (in_valid_i / in_stall_o) carries req_type_i, pid_i and
//   priority_req_i; a transaction is taken when valid is high and stall low
// - result channel (out_valid_o / out_stall_i) carries status_o, pid_out_o,
//   is_empty_o and last_o from an output register
// - config channel (cfg_valid_i / cfg_ready_o) writes cpu_count; ready is
//   always high, write only while the block is idle
// - enqueue, dequeue, peek and unused codes: result in the cycle after accept
// - sort: DEPTH odd-even compare-swap rounds, then the result
// - remove: mark, DEPTH - 1 mark-propagation steps, a turnaround step, then
//   a shift
// - snapshot: one result per cycle, while the output is not stalled, from cell 0
//   while the ring rotates, then rotation up to DEPTH steps
// - one request in work at a time; a new one is taken once the fsm is idle
//   and the output register is free
// - reset empties the queue and sets cpu_count to 1; a stalled result holds
//   the fsm and the chain until it is taken, but the snapshot rotation goes on
`include "priority_ready_queue_defines.svh"

module priority_ready_queue import prq_pkg::*; #(
  parameter int unsigned DEPTH    = 32,
  parameter int unsigned MAX_CPUS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       req_type_i,
  input  logic [PID_W-1:0] pid_i,
  input  logic [PRI_W-1:0] priority_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [PID_W-1:0] pid_out_o,
  output logic             is_empty_o,
  output logic             last_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CPU_W-1:0] cfg_data_i
);

  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned NW = $clog2(MAX_CPUS + 1);

  st_e              state_q, state_d;
  logic [OW-1:0]    occ_q, occ_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [NW-1:0]    k_q, k_d;
  logic [NW-1:0]    n_q, n_d;
  logic [NW-1:0]    n_c;
  logic [PID_W-1:0] req_pid_q, req_pid_d;
  logic [CPU_W-1:0] cpu_q;

  logic             out_valid_q;
  logic [1:0]       out_status_q;
  logic [PID_W-1:0] out_pid_q;
  logic             out_empty_q;
  logic             out_last_q;

  logic             out_free;
  logic             in_acc;
  logic             out_load;
  logic [1:0]       status_c;
  logic [PID_W-1:0] pid_c;
  logic             last_c;
  cell_op_e         op_c;
  logic             k_in_queue;
  logic             k_final;

  entry_t           ent   [DEPTH];
  logic             mark  [DEPTH];
  cell_ctrl_t       ctrl  [DEPTH];

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == S_IDLE) && out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign k_in_queue  = 32'(k_q) < 32'(occ_q);
  assign k_final     = (k_q + NW'(1)) == n_q;

  always_comb begin
    if (cpu_q == '0) begin
      n_c = NW'(1);
    end else if (32'(cpu_q) > MAX_CPUS) begin
      n_c = NW'(MAX_CPUS);
    end else begin
      n_c = NW'(cpu_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            REQ_SORT: state_d = S_SORT;
            REQ_REM:  state_d = (occ_q == '0) ? S_IDLE : S_REM_MARK;
            REQ_SNAP: state_d = S_SNAP;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_SORT: begin
        if ((cnt_q == CW'(DEPTH)) && out_free) begin
          state_d = S_IDLE;
        end
      end
      S_REM_MARK: begin
        state_d = S_REM_SPREAD;
      end
      S_REM_SPREAD: begin
        if (cnt_q == CW'(DEPTH - 1)) begin
          state_d = S_REM_SHIFT;
        end
      end
      S_REM_SHIFT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SNAP: begin
        if (out_free && k_final) begin
          state_d = S_ROT;
        end
      end
      S_ROT: begin
        if (cnt_q == CW'(DEPTH)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath control and results
  always_comb begin
    op_c      = CELL_HOLD;
    occ_d     = occ_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    n_d       = n_q;
    req_pid_d = req_pid_q;
    out_load  = 1'b0;
    status_c  = STAT_OK;
    pid_c     = '0;
    last_c    = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_pid_d = pid_i;
          cnt_d     = '0;
          k_d       = '0;
          n_d       = n_c;
          case (req_type_i)
            REQ_ENQ: begin
              out_load = 1'b1;
              if (occ_q == OW'(DEPTH)) begin
                status_c = STAT_FULL;
              end else begin
                op_c  = CELL_LOAD;
                occ_d = occ_q + OW'(1);
              end
            end
            REQ_DEQ: begin
              out_load = 1'b1;
              if (occ_q == '0) begin
                status_c = STAT_EMPTY;
              end else begin
                op_c  = CELL_SHIFT;
                pid_c = ent[0].pid;
                occ_d = occ_q - OW'(1);
              end
            end
            REQ_REM: begin
              if (occ_q == '0) begin
                out_load = 1'b1;
                status_c = STAT_EMPTY;
              end
            end
            REQ_PEEK: begin
              out_load = 1'b1;
              if (occ_q == '0) begin
                status_c = STAT_EMPTY;
              end else begin
                pid_c = ent[0].pid;
              end
            end
            REQ_SORT, REQ_SNAP: begin
              out_load = 1'b0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_SORT: begin
        if (cnt_q != CW'(DEPTH)) begin
          op_c  = CELL_SORT;
          cnt_d = cnt_q + CW'(1);
        end else if (out_free) begin
          out_load = 1'b1;
        end
      end
      S_REM_MARK: begin
        op_c  = CELL_MARK;
        cnt_d = '0;
      end
      S_REM_SPREAD: begin
        if (cnt_q != CW'(DEPTH - 1)) begin
          op_c  = CELL_SPREAD;
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_REM_SHIFT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (mark[DEPTH-1]) begin
            op_c  = CELL_SHIFT_MARKED;
            occ_d = occ_q - OW'(1);
          end else begin
            status_c = STAT_NOTFOUND;
          end
        end
      end
      S_SNAP: begin
        if (out_free) begin
          out_load = 1'b1;
          last_c   = k_final;
          if (k_in_queue) begin
            pid_c = ent[0].pid;
            op_c  = CELL_SHIFT;
            cnt_d = cnt_q + CW'(1);
          end
          if (!k_final) begin
            k_d = k_q + NW'(1);
          end
        end
      end
      S_ROT: begin
        if (cnt_q != CW'(DEPTH)) begin
          op_c  = CELL_SHIFT;
          cnt_d = cnt_q + CW'(1);
        end
      end
      default: begin
        op_c = CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      n_q         <= NW'(1);
      cpu_q       <= CPU_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      n_q     <= n_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cpu_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_pid_q <= req_pid_d;
    if (out_load) begin
      out_status_q <= status_c;
      out_pid_q    <= pid_c;
      out_empty_q  <= (occ_d == '0);
      out_last_q   <= last_c;
    end
  end

  entry_t load_c;
  assign load_c.pid = pid_i;
  assign load_c.pri = priority_req_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic occ_here;
    logic occ_next;
    logic pair_left;
    logic left_mark;

    assign occ_here  = OW'(i) < occ_q;
    assign pair_left = (i % 2) == int'(cnt_q[0]);

    if (i + 1 < DEPTH) begin : g_next
      assign occ_next = OW'(i + 1) < occ_q;
    end else begin : g_end
      assign occ_next = 1'b0;
    end

    if (i == 0) begin : g_first
      assign left_mark = 1'b0;
    end else begin : g_rest
      assign left_mark = mark[i-1];
    end

    assign ctrl[i].op         = op_c;
    assign ctrl[i].occupied   = occ_here;
    assign ctrl[i].tail       = OW'(i) == occ_q;
    assign ctrl[i].sort_left  = pair_left && occ_next;
    assign ctrl[i].sort_right = !pair_left && (i > 0) && occ_here;

    prq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl[i]),
      .load_i      (load_c),
      .cmp_pid_i   (req_pid_q),
      .left_i      (ent[(i + DEPTH - 1) % DEPTH]),
      .left_mark_i (left_mark),
      .right_i     (ent[(i + 1) % DEPTH]),
      .ent_o       (ent[i]),
      .mark_o      (mark[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign pid_out_o   = out_pid_q;
  assign is_empty_o  = out_empty_q;
  assign last_o      = out_last_q;

  `PRQ_ASSERT(a_occ_bound, occ_q <= OW'(DEPTH), "occupancy above depth")
  `PRQ_IMPLIES(a_acc_idle, in_acc, state_q == S_IDLE, "request taken while busy")
  `PRQ_NEXT(a_enq_grow, in_acc && (req_type_i == REQ_ENQ) && (occ_q != OW'(DEPTH)),
            occ_q == ($past(occ_q) + OW'(1)), "enqueue did not grow the queue")
  `PRQ_IMPLIES(a_snap_last, out_load && (state_q == S_SNAP) && !k_final, !last_c,
               "snapshot marked last too early")

endmodule

@@ tb/tb_priority_ready_queue.sv @@
// self-checking testbench for priority_ready_queue: directed and random requests,
// a scoreboard of predicted results, random idling on both channels
// depends on prq_pkg and the priority_ready_queue top level
`timescale 1ns / 100ps

module tb_priority_ready_queue;
  import prq_pkg::*;

  localparam int unsigned DEPTH      = 32;
  localparam int unsigned MAX_CPUS   = 8;
  localparam int unsigned SETTLE     = 4 * DEPTH;
  localparam int unsigned LONG_HOLD  = 300;
  localparam logic [PID_W-1:0] PID_MAX = {PID_W{1'b1}};
  localparam logic [2:0] REQ_UNUSED_A = 3'd6;
  localparam logic [2:0] REQ_UNUSED_B = 3'd7;

  typedef struct packed {
    logic [2:0]       req;
    logic [PID_W-1:0] pid;
    logic [PRI_W-1:0] pri;
  } request_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PID_W-1:0] pid;
    logic             empty;
    logic             last;
  } queue_result_t;

  logic             clk_i;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall_o;
  logic [2:0]       req_type     = REQ_PEEK;
  logic [PID_W-1:0] pid          = '0;
  logic [PRI_W-1:0] priority_req = '0;
  logic             out_valid_o;
  logic             out_stall    = 1'b0;
  logic [1:0]       status_o;
  logic [PID_W-1:0] pid_out_o;
  logic             is_empty_o;
  logic             last_o;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready_o;
  logic [CPU_W-1:0] cfg_data     = '0;

  // shadow of the ready queue
  logic [PID_W-1:0] shadow_pid [DEPTH];
  logic [PRI_W-1:0] shadow_pri [DEPTH];
  int unsigned      shadow_count = 0;
  logic [CPU_W-1:0] shadow_cpus  = 4'd1;

  request_t         request_q[$];
  queue_result_t    result_q[$];
  request_t         next_request;
  logic [PID_W-1:0] id_pool [8];
  int unsigned      issued_cnt   = 0;
  int unsigned      accepted_cnt = 0;
  int unsigned      gap_left     = 0;
  int unsigned      stall_left   = 0;
  int unsigned      errors       = 0;
  bit               idle_on      = 1'b1;
  int unsigned      hold_req_cnt = 0;
  int unsigned      hold_ack_cnt = 0;

  priority_ready_queue #(
    .DEPTH    (DEPTH),
    .MAX_CPUS (MAX_CPUS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type),
    .pid_i          (pid),
    .priority_req_i (priority_req),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .status_o       (status_o),
    .pid_out_o      (pid_out_o),
    .is_empty_o     (is_empty_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  task automatic push_result(input logic [1:0] st, input logic [PID_W-1:0] id,
                             input logic fin);
    result_q.push_back('{st, id, (shadow_count == 0), fin});
  endtask

  task automatic close_gap(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
      shadow_pid[i] = shadow_pid[i+1];
      shadow_pri[i] = shadow_pri[i+1];
    end
    shadow_count--;
  endtask

  // apply one request to the shadow queue and record the results it causes
  task automatic schedule_request(input request_t rq);
    logic [PID_W-1:0] head;
    logic [PRI_W-1:0] key;
    int unsigned      j;
    int unsigned      n;
    bit               found;
    head  = '0;
    found = 1'b0;
    case (rq.req)
      REQ_ENQ: begin
        if (shadow_count >= DEPTH) begin
          push_result(STAT_FULL, '0, 1'b1);
        end else begin
          shadow_pid[shadow_count] = rq.pid;
          shadow_pri[shadow_count] = rq.pri;
          shadow_count++;
          push_result(STAT_OK, '0, 1'b1);
        end
      end
      REQ_DEQ: begin
        if (shadow_count == 0) begin
          push_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          head = shadow_pid[0];
          close_gap(0);
          push_result(STAT_OK, head, 1'b1);
        end
      end
      REQ_SORT: begin
        // stable insertion sort, ties keep arrival order
        for (int unsigned i = 1; i < shadow_count; i++) begin
          head = shadow_pid[i];
          key  = shadow_pri[i];
          j    = i;
          while (j > 0 && shadow_pri[j-1] > key) begin
            shadow_pid[j] = shadow_pid[j-1];
            shadow_pri[j] = shadow_pri[j-1];
            j--;
          end
          shadow_pid[j] = head;
          shadow_pri[j] = key;
        end
        push_result(STAT_OK, '0, 1'b1);
      end
      REQ_REM: begin
        if (shadow_count == 0) begin
          push_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < shadow_count && !found; i++) begin
            if (shadow_pid[i] == rq.pid) begin
              close_gap(i);
              found = 1'b1;
            end
          end
          push_result(found ? STAT_OK : STAT_NOTFOUND, '0, 1'b1);
        end
      end
      REQ_PEEK: begin
        if (shadow_count == 0) push_result(STAT_EMPTY, '0, 1'b1);
        else push_result(STAT_OK, shadow_pid[0], 1'b1);
      end
      REQ_SNAP: begin
        n = 32'(shadow_cpus);
        if (n == 0) n = 1;
        if (n > MAX_CPUS) n = MAX_CPUS;
        for (int unsigned i = 0; i < n; i++) begin
          push_result(STAT_OK, (i < shadow_count) ? shadow_pid[i] : '0, (i + 1 == n));
        end
      end
      default: push_result(STAT_OK, '0, 1'b1);
    endcase
  endtask

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        schedule_request('{req_type, pid, priority_req});
        accepted_cnt++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          next_request = request_q.pop_front();
          in_valid     <= 1'b1;
          req_type     <= next_request.req;
          pid          <= next_request.pid;
          priority_req <= next_request.pri;
          gap_left = draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver stall
  always @(posedge clk_i) begin
    int unsigned r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_req_cnt != hold_ack_cnt) begin
        hold_ack_cnt = hold_req_cnt;
        stall_left = LONG_HOLD;
      end
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!idle_on || r < 60) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  task automatic check_field(input string name, input logic [PID_W-1:0] want,
                             input logic [PID_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0h pid %0h",
                 $time, status_o, pid_out_o);
      end else begin
        want = result_q.pop_front();
        check_field("status", PID_W'(want.status), PID_W'(status_o));
        check_field("pid_out", want.pid, pid_out_o);
        check_field("is_empty", PID_W'(want.empty), PID_W'(is_empty_o));
        check_field("last", PID_W'(want.last), PID_W'(last_o));
      end
    end
  end

  task automatic queue_request(input logic [2:0] req, input logic [PID_W-1:0] id,
                               input logic [PRI_W-1:0] pri);
    request_q.push_back('{req, id, pri});
    issued_cnt++;
  endtask

  task automatic write_cpu_count(input logic [CPU_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_cpus = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (accepted_cnt != issued_cnt || result_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic add_random_requests(input int unsigned count, input int unsigned enq_pct);
    int unsigned      r;
    logic [2:0]       req;
    logic [PID_W-1:0] id;
    logic [PRI_W-1:0] pri;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct) begin
        req = REQ_ENQ;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20) req = REQ_DEQ;
        else if (r < 35) req = REQ_SORT;
        else if (r < 57) req = REQ_REM;
        else if (r < 72) req = REQ_PEEK;
        else if (r < 94) req = REQ_SNAP;
        else if (r < 97) req = REQ_UNUSED_A;
        else req = REQ_UNUSED_B;
      end
      if ($urandom_range(0, 99) < 60) id = id_pool[$urandom_range(0, 7)];
      else id = PID_W'($urandom());
      r = $urandom_range(0, 99);
      if (r < 12) pri = '0;
      else if (r < 24) pri = '1;
      else if (r < 35) pri = 8'd17;
      else pri = PRI_W'($urandom_range(0, 255));
      queue_request(req, id, pri);
    end
  endtask

  task automatic run_phase(input logic [CPU_W-1:0] cpus, input bit idle, input bit hold,
                           input int unsigned count, input int unsigned enq_pct);
    write_cpu_count(cpus);
    idle_on = idle;
    id_pool[0] = PID_MAX;
    id_pool[1] = '0;
    for (int unsigned k = 2; k < 8; k++) id_pool[k] = PID_W'($urandom());
    if (hold) hold_req_cnt++;
    add_random_requests(count, enq_pct);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;

    // empty queue, unused codes, single entry, ties, duplicates, draining
    queue_request(REQ_PEEK, '0, '0);
    queue_request(REQ_DEQ, '0, '0);
    queue_request(REQ_REM, 22'h5, '0);
    queue_request(REQ_SORT, '0, '0);
    queue_request(REQ_SNAP, '0, '0);
    queue_request(REQ_UNUSED_A, PID_MAX, '1);
    queue_request(REQ_UNUSED_B, 22'h155555, 8'h55);
    queue_request(REQ_ENQ, PID_MAX, '1);
    queue_request(REQ_SORT, '0, '0);
    queue_request(REQ_PEEK, '0, '0);
    queue_request(REQ_ENQ, '0, '0);
    queue_request(REQ_ENQ, 22'h155555, '1);
    queue_request(REQ_ENQ, 22'h2AAAAA, 8'h80);
    queue_request(REQ_SORT, '0, '0);
    queue_request(REQ_SNAP, '0, '0);
    queue_request(REQ_REM, 22'h123, '0);
    queue_request(REQ_REM, PID_MAX, '0);
    queue_request(REQ_ENQ, '0, 8'h07);
    queue_request(REQ_REM, '0, '0);
    queue_request(REQ_DEQ, '0, '0);
    queue_request(REQ_DEQ, '0, '0);
    queue_request(REQ_DEQ, '0, '0);
    queue_request(REQ_DEQ, '0, '0);
    wait_drained();

    run_phase(4'd8, 1'b1, 1'b0, 25, 40);
    run_phase(4'd15, 1'b1, 1'b1, 45, 90);
    run_phase(4'd0, 1'b0, 1'b0, 28, 15);
    run_phase(CPU_W'($urandom_range(2, 7)), 1'b1, 1'b0, 22, 45);
    run_phase(4'd9, 1'b1, 1'b0, 12, 35);
    run_phase(4'd1, 1'b1, 1'b0, 5, 50);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
